/* rtl/mrtu_pkg.sv */
`timescale 1ns / 1ps

package mrtu_pkg;

    localparam int MAX_FRAME_DEFAULT = 256;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;
    localparam logic [7:0] BROADCAST_ADDRESS   = 8'h00;
    localparam logic [7:0] FUNC_WRITE_MULTIPLE = 8'h10;

    localparam int POS_ADDRESS    = 0;
    localparam int POS_FUNCTION   = 1;
    localparam int POS_BYTE_COUNT = 6;
    localparam int FIRST_FORWARD  = 3;
    localparam int MIN_FRAME      = 6;
    localparam int WRITE_MULTIPLE_OVERHEAD = 9;
    localparam int FRAME_OVERHEAD = 3;
    localparam int PAYLOAD_LENGTH_MAX = 255;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED   = 2'd0,
        STATUS_CRC_ERROR  = 2'd1,
        STATUS_ADDR_MISS  = 2'd2,
        STATUS_OVERFLOW   = 2'd3
    } status_t;

    typedef struct packed {
        logic       gap;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        status_t    status;
        logic       broadcast;
        logic [7:0] payload_length;
    } result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/mrtu_in_reg.sv */
`timescale 1ns / 1ps

module mrtu_in_reg
    import mrtu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  rx_item_t in_item,
    input  logic     out_free,
    output logic     advance,
    output rx_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;
    logic     load;

    assign advance  = valid_reg && out_free;
    assign in_stall = valid_reg && !out_free;
    assign load     = in_valid && !in_stall;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* rtl/mrtu_frame_core.sv */
`timescale 1ns / 1ps

module mrtu_frame_core
    import mrtu_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  rx_item_t   item,
    input  logic [7:0] slave_address,
    output logic       res_valid,
    output result_t    res
);

    localparam int CW   = $clog2(MAX_FRAME + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;

    logic [15:0]   crc_reg;
    logic [15:0]   crc_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    frame_address_reg;
    logic [7:0]    frame_address_next;
    logic [7:0]    function_code_reg;
    logic [7:0]    function_code_next;
    logic [7:0]    write_byte_count_reg;
    logic [7:0]    write_byte_count_next;
    logic [7:0]    delay0_reg;
    logic [7:0]    delay0_next;
    logic [7:0]    delay1_reg;
    logic [7:0]    delay1_next;
    logic          overflowed_reg;
    logic          overflowed_next;

    logic          addr_ok;
    logic          too_short;
    logic          write_multiple_short;
    logic [CW-1:0] plen_full;
    logic [7:0]    plen;

    assign addr_ok = (frame_address_reg == BROADCAST_ADDRESS)
                  || (frame_address_reg == slave_address);
    assign too_short = count_reg < CW'(MIN_FRAME);
    assign write_multiple_short = (function_code_reg == FUNC_WRITE_MULTIPLE)
        && (CMPW'(count_reg) < (CMPW'(write_byte_count_reg) + CMPW'(WRITE_MULTIPLE_OVERHEAD)));
    assign plen_full = count_reg - CW'(FRAME_OVERHEAD);

    always_comb
    begin
        if (count_reg < CW'(FRAME_OVERHEAD))
        begin
            plen = 8'h00;
        end
        else if (CMPW'(plen_full) > CMPW'(PAYLOAD_LENGTH_MAX))
        begin
            plen = 8'(PAYLOAD_LENGTH_MAX);
        end
        else
        begin
            plen = 8'(plen_full);
        end
    end

    always_comb
    begin
        crc_next              = crc_reg;
        count_next            = count_reg;
        frame_address_next    = frame_address_reg;
        function_code_next    = function_code_reg;
        write_byte_count_next = write_byte_count_reg;
        delay0_next           = delay0_reg;
        delay1_next           = delay1_reg;
        overflowed_next       = overflowed_reg;
        res_valid             = 1'b0;
        res                   = '0;

        if (!item.gap)
        begin
            if (CMPW'(count_reg) >= CMPW'(MAX_FRAME))
            begin
                overflowed_next = 1'b1;
            end
            else
            begin
                if (count_reg == CW'(POS_ADDRESS))
                begin
                    frame_address_next = item.rx_byte;
                end
                else if (count_reg == CW'(POS_FUNCTION))
                begin
                    function_code_next = item.rx_byte;
                end
                else if (count_reg == CW'(POS_BYTE_COUNT))
                begin
                    write_byte_count_next = item.rx_byte;
                end
                crc_next = crc16_update(crc_reg, item.rx_byte);
                if ((count_reg >= CW'(FIRST_FORWARD)) && addr_ok)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_PAYLOAD;
                    res.data  = delay0_reg;
                end
                delay0_next = delay1_reg;
                delay1_next = item.rx_byte;
                count_next  = count_reg + CW'(1);
            end
        end
        else if (overflowed_reg || !(too_short || write_multiple_short))
        begin
            res_valid          = 1'b1;
            res.kind           = KIND_STATUS;
            res.broadcast      = (frame_address_reg == BROADCAST_ADDRESS);
            res.payload_length = plen;
            if (overflowed_reg)
            begin
                res.status = STATUS_OVERFLOW;
            end
            else if (crc_reg != 16'h0000)
            begin
                res.status = STATUS_CRC_ERROR;
            end
            else if (!addr_ok)
            begin
                res.status = STATUS_ADDR_MISS;
            end
            else
            begin
                res.status = STATUS_ACCEPTED;
            end
            crc_next              = CRC_SEED;
            count_next            = '0;
            frame_address_next    = 8'h00;
            function_code_next    = 8'h00;
            write_byte_count_next = 8'h00;
            delay0_next           = 8'h00;
            delay1_next           = 8'h00;
            overflowed_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg              <= CRC_SEED;
            count_reg            <= '0;
            frame_address_reg    <= 8'h00;
            function_code_reg    <= 8'h00;
            write_byte_count_reg <= 8'h00;
            delay0_reg           <= 8'h00;
            delay1_reg           <= 8'h00;
            overflowed_reg       <= 1'b0;
        end
        else if (advance)
        begin
            crc_reg              <= crc_next;
            count_reg            <= count_next;
            frame_address_reg    <= frame_address_next;
            function_code_reg    <= function_code_next;
            write_byte_count_reg <= write_byte_count_next;
            delay0_reg           <= delay0_next;
            delay1_reg           <= delay1_next;
            overflowed_reg       <= overflowed_next;
        end
    end

endmodule

/* rtl/mrtu_out_reg.sv */
`timescale 1ns / 1ps

module mrtu_out_reg
    import mrtu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

/* rtl/modbus_rtu_frame_receiver_core.sv */
`timescale 1ns / 1ps

// Modbus RTU request receiver with a running CRC-16 check.
// The input channel (in_valid, in_stall) carries one received byte per transfer, or a
// gap marker when the line has been idle long enough for the frame to end.
// The output channel (out_valid, out_stall) delivers payload bytes (kind 0) from the
// function code through the last data byte, two bytes behind reception, while the frame
// address is broadcast or matches slave_address, and one status transfer (kind 1) when a
// gap closes a frame long enough to be complete or one that overflowed MAX_FRAME.
// The configuration channel (cfg_valid, cfg_ready) writes slave_address; cfg_ready is
// always high and writes are expected only while the block is idle.
// One item is accepted per cycle while in_stall is low. Each accepted item is held in the
// input register, where the frame core applies the CRC byte update, and any result it
// causes is loaded into the output register, from which it is offered; items that cause
// no result still pass through the input register.
// When out_stall is held, the output register keeps its transfer, one more item can wait
// in the input register, and then in_stall rises until the output is taken.
// Reset clears the frame state, sets the CRC seed and sets slave_address to 1.
module modbus_rtu_frame_receiver_core
    import mrtu_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       gap,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data,
    output logic [1:0] status,
    output logic       broadcast,
    output logic [7:0] payload_length,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] slave_address_reg;
    rx_item_t   in_item;
    rx_item_t   item;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign cfg_ready     = 1'b1;
    assign in_item.gap     = gap;
    assign in_item.rx_byte = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_ADDRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slave_address_reg <= cfg_data;
        end
    end

    mrtu_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_free (out_free),
        .advance  (advance),
        .item     (item)
    );

    mrtu_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (item),
        .slave_address (slave_address_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    mrtu_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind           = out_res.kind;
    assign data           = out_res.data;
    assign status         = out_res.status;
    assign broadcast      = out_res.broadcast;
    assign payload_length = out_res.payload_length;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import mrtu_pkg::*;

    localparam int FRAME_LIMIT = MAX_FRAME_DEFAULT;
    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam int ITEMS_PER_PHASE = 385;

    class frame_scoreboard;
        int unsigned frame_limit;
        logic [7:0] station;
        logic [15:0] crc;
        int unsigned byte_total;
        logic [7:0] frame_addr;
        logic [7:0] func;
        logic [7:0] write_count;
        logic [7:0] held [2];
        bit overflowed;
        result_t expected_q [$];
        int errors;

        function new(int unsigned limit);
            frame_limit = limit;
            station = SLAVE_ADDRESS_RESET;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc = CRC_SEED;
            byte_total = 0;
            frame_addr = '0;
            func = '0;
            write_count = '0;
            held[0] = '0;
            held[1] = '0;
            overflowed = 0;
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] acc;
            acc = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++)
            begin
                if (acc[0])
                begin
                    acc = (acc >> 1) ^ CRC_POLY;
                end
                else
                begin
                    acc = acc >> 1;
                end
            end
            return acc;
        endfunction

        function bit station_match();
            return frame_addr == BROADCAST_ADDRESS || frame_addr == station;
        endfunction

        function void note_transfer(logic g, logic [7:0] b);
            result_t r;
            int unsigned plen;
            r = '0;
            if (!g)
            begin
                if (byte_total >= frame_limit)
                begin
                    overflowed = 1;
                    return;
                end
                if (byte_total == POS_ADDRESS)
                begin
                    frame_addr = b;
                end
                else if (byte_total == POS_FUNCTION)
                begin
                    func = b;
                end
                else if (byte_total == POS_BYTE_COUNT)
                begin
                    write_count = b;
                end
                crc = crc_step(crc, b);
                if (byte_total >= FIRST_FORWARD && station_match())
                begin
                    r.kind = KIND_PAYLOAD;
                    r.data = held[0];
                    expected_q.push_back(r);
                end
                held[0] = held[1];
                held[1] = b;
                byte_total++;
                return;
            end
            if (!overflowed)
            begin
                if (byte_total < MIN_FRAME)
                begin
                    return;
                end
                if (func == FUNC_WRITE_MULTIPLE
                    && byte_total < write_count + WRITE_MULTIPLE_OVERHEAD)
                begin
                    return;
                end
            end
            plen = byte_total >= FRAME_OVERHEAD ? byte_total - FRAME_OVERHEAD : 0;
            if (plen > PAYLOAD_LENGTH_MAX)
            begin
                plen = PAYLOAD_LENGTH_MAX;
            end
            r.kind = KIND_STATUS;
            if (overflowed)
            begin
                r.status = STATUS_OVERFLOW;
            end
            else if (crc != 16'h0000)
            begin
                r.status = STATUS_CRC_ERROR;
            end
            else if (!station_match())
            begin
                r.status = STATUS_ADDR_MISS;
            end
            else
            begin
                r.status = STATUS_ACCEPTED;
            end
            r.broadcast = frame_addr == BROADCAST_ADDRESS;
            r.payload_length = plen[7:0];
            expected_q.push_back(r);
            clear_frame();
        endfunction

        function void check_result(logic k, logic [7:0] d, logic [1:0] s, logic bc,
                                   logic [7:0] pl);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer: kind %0d data %02h status %0d", k, d, s);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (k !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, k);
                errors++;
            end
            if (d !== e.data)
            begin
                $error("data: expected %02h, actual %02h", e.data, d);
                errors++;
            end
            if (s !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, s);
                errors++;
            end
            if (bc !== e.broadcast)
            begin
                $error("broadcast: expected %0d, actual %0d", e.broadcast, bc);
                errors++;
            end
            if (pl !== e.payload_length)
            begin
                $error("payload_length: expected %0d, actual %0d", e.payload_length, pl);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       gap;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       broadcast;
    logic [7:0] payload_length;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    frame_scoreboard sb;
    logic [7:0] frame_buf [$];
    logic [7:0] cur_address;
    int unsigned items_sent;
    int idle_pct;
    int stall_pct;

    modbus_rtu_frame_receiver_core #(
        .MAX_FRAME(FRAME_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .gap(gap),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .data(data),
        .status(status),
        .broadcast(broadcast),
        .payload_length(payload_length),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        out_stall <= $urandom_range(0, 99) < stall_pct;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            sb.note_transfer(gap, rx_byte);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(kind, data, status, broadcast, payload_length);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            sb.station = cfg_data;
        end
    end

    task automatic send_item(input logic g, input logic [7:0] b);
        logic stalled;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        gap <= g;
        rx_byte <= b;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_address(input logic [7:0] a);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_data <= a;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        cur_address = a;
    endtask

    function automatic logic [7:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return cur_address;
        end
        if (r < 70)
        begin
            return BROADCAST_ADDRESS;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic build_request(input logic [7:0] addr, input bit write_multiple,
                                 input int unsigned count_byte);
        logic [7:0] f;
        frame_buf.delete();
        frame_buf.push_back(addr);
        if (write_multiple)
        begin
            frame_buf.push_back(FUNC_WRITE_MULTIPLE);
        end
        else
        begin
            f = 8'($urandom_range(0, 255));
            if (f == FUNC_WRITE_MULTIPLE)
            begin
                f = FUNC_READ_HOLDING;
            end
            frame_buf.push_back(f);
        end
        repeat (4) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (write_multiple)
        begin
            frame_buf.push_back(count_byte[7:0]);
            repeat (count_byte) frame_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // The CRC is appended low byte first; a single flipped bit always breaks it.
    task automatic send_frame(input bit corrupt, input int cut, input int pad_to,
                              input bit close);
        logic [15:0] c;
        int idx;
        c = CRC_SEED;
        foreach (frame_buf[i])
        begin
            c = sb.crc_step(c, frame_buf[i]);
        end
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
        while (frame_buf.size() < pad_to)
        begin
            frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (corrupt)
        begin
            idx = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (cut >= 0)
        begin
            while (frame_buf.size() > cut)
            begin
                void'(frame_buf.pop_back());
            end
        end
        foreach (frame_buf[i])
        begin
            send_item(1'b0, frame_buf[i]);
        end
        if (close)
        begin
            send_item(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_frame();
        int r;
        bit wm;
        int unsigned bc;
        r = $urandom_range(0, 99);
        wm = $urandom_range(0, 2) == 0;
        bc = $urandom_range(0, 3) == 0 ? $urandom_range(9, 40) : $urandom_range(0, 8);
        build_request(pick_address(), wm, bc);
        if (r < 65)
        begin
            send_frame(1'b0, -1, 0, 1'b1);
        end
        else if (r < 77)
        begin
            send_frame(1'b1, -1, 0, 1'b1);
        end
        else if (r < 88)
        begin
            send_frame(1'b0, $urandom_range(1, frame_buf.size() + 1), 0, 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                send_item($urandom_range(0, 4) == 0, 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 4) == 0)
        begin
            send_item(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        gap = 1'b0;
        rx_byte = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        cur_address = SLAVE_ADDRESS_RESET;
        sb = new(FRAME_LIMIT);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Gap on an empty receiver, then complete frames under the reset address.
        send_item(1'b1, 8'hFF);
        frame_buf = '{SLAVE_ADDRESS_RESET, FUNC_READ_HOLDING, 8'h00, 8'hFF, 8'h00, 8'hFF};
        send_frame(1'b0, -1, 0, 1'b1);
        frame_buf = '{BROADCAST_ADDRESS, FUNC_WRITE_MULTIPLE, 8'h12, 8'h34, 8'h00, 8'h00,
                      8'h00};
        send_frame(1'b0, -1, 0, 1'b1);
        // A short frame closed by a gap keeps accumulating into the next bytes.
        frame_buf = '{SLAVE_ADDRESS_RESET, 8'h06, 8'hAA};
        foreach (frame_buf[i])
        begin
            send_item(1'b0, frame_buf[i]);
        end
        send_item(1'b1, 8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0: write_address(8'd247);
                1: write_address(8'($urandom_range(1, 247)));
                2: write_address(8'd1);
                default: write_address(8'($urandom_range(1, 247)));
            endcase
            idle_pct = (ph == 1) ? 60 : (ph == 3) ? 28 : 0;
            stall_pct = (ph == 2) ? 60 : (ph == 3) ? 28 : 0;
            if (ph == 1)
            begin
                build_request(pick_address(), 1'b1, $urandom_range(248, 255));
                send_frame(1'b0, -1, FRAME_LIMIT + 1 + $urandom_range(0, 3), 1'b1);
            end
            if (ph == 3)
            begin
                build_request(cur_address, 1'b1, FRAME_LIMIT - WRITE_MULTIPLE_OVERHEAD);
                send_frame(1'b0, -1, 0, 1'b1);
            end
            while (items_sent < (ph + 1) * ITEMS_PER_PHASE)
            begin
                random_frame();
            end
            // Leave a frame open so the next address takes effect mid-frame.
            if (ph < 3)
            begin
                build_request(cur_address, 1'b0, 0);
                send_frame(1'b0, 4, 0, 1'b0);
            end
        end
        send_item(1'b1, 8'h00);
        settle();
        if (sb.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
